// ===== rtl/best_fit_coalescing_allocator_defines.svh =====
// assertion macros for the best-fit allocator checker
// expects clk and rst_n in the scope where a macro is used
`ifndef BEST_FIT_COALESCING_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_COALESCING_ALLOCATOR_DEFINES_SVH

// same-cycle implication, quiet during reset
`define BFA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bfa assertion failed");

// next-cycle implication, quiet during reset
`define BFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfa assertion failed");

`endif

// ===== rtl/bfa_pkg.sv =====
// shared types and constants of the best-fit allocator
// no dependencies
`timescale 1ns / 1ps
package bfa_pkg;

  localparam int ADDR_W   = 32;
  localparam int SIZE_W   = 33;
  localparam int EXT_W    = 34;
  localparam int FREE_ENTRIES = 32;
  localparam int ENT_W    = $clog2(FREE_ENTRIES);
  localparam int MOD_W    = 17;   // holds page sizes up to 64 KiB

  localparam logic [31:0] GROW_RESET  = 32'd16777216;
  localparam logic [31:0] LIMIT_RESET = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_OVERLAP = 3'd1,
    ST_FULL    = 3'd2,
    ST_SPACE   = 3'd3,
    ST_ZERO    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_INIT  = 2'd0,
    REG_GROW  = 2'd1,
    REG_LIMIT = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RNDGO, S_RND, S_PRIME, S_SCANGO, S_SCAN, S_UPD, S_DONE
  } state_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    logic [EXT_W-1:0]  span_end;
  } req_t;

  typedef struct packed {
    logic              we;
    logic [ENT_W-1:0]  widx;
    logic [ADDR_W-1:0] wstart;
    logic [SIZE_W-1:0] wsize;
    logic              clr;
    logic [ENT_W-1:0]  cidx;
  } cmd_t;

  typedef struct packed {
    logic              vld;
    logic              best_hit;
    logic [ENT_W-1:0]  best_idx;
    logic [ADDR_W-1:0] best_start;
    logic [SIZE_W-1:0] best_size;
    logic              ovl;
    logic              low_hit;
    logic [ENT_W-1:0]  low_idx;
    logic [ADDR_W-1:0] low_start;
    logic [SIZE_W-1:0] low_size;
    logic              up_hit;
    logic [ENT_W-1:0]  up_idx;
    logic [SIZE_W-1:0] up_size;
    logic              emp_hit;
    logic [ENT_W-1:0]  emp_idx;
  } rec_t;

endpackage

// ===== rtl/best_fit_coalescing_allocator.sv =====
// top level of the best-fit coalescing space allocator
// depends on bfa_pkg, bfa_mod and bfa_cell
//
//  channel  handshake              payload
//  in       in_valid / in_ready    in_op, in_region_addr, in_region_bytes
//  out      out_valid / out_ready  out_alloc_addr, out_status
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one request at a time; the next request is accepted only after the result enters the output register
// the result waits for the scan token to walk the cell row
// page and alignment sizes are powers of two; rounding masks the low bits
// reset is synchronous; it empties the table and the pool
// a finished result waits in the output register while the next request enters
`timescale 1ns / 1ps
module best_fit_coalescing_allocator import bfa_pkg::*; #(
  parameter int PAGE_BYTES   = 4096,
  parameter int ALIGN_BYTES  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [31:0] in_region_addr,
  input  logic [31:0] in_region_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_alloc_addr,
  output logic [2:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers
  logic [31:0] init_bytes_r, grow_bytes_r, pool_limit_r;

  state_t state_r, state_nxt;

  // request
  logic              op_r;
  logic [ADDR_W-1:0] addr_r;
  logic [31:0]       bytes_r;

  // rounded sizes
  logic [SIZE_W-1:0] size_r, grow_pg_r, init_pg_r, size_pg_r;
  logic              pg_done_r, scan_done_r;
  rec_t              scan_r;

  // pool state
  logic [SIZE_W-1:0] pool_end_r, pool_end_nxt;
  logic              primed_r, primed_nxt;

  // result
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  status_t           res_st_r, res_st_nxt;
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  status_t           out_st_r;

  // remainder units
  logic              a_go, bc_go, a_done, b_done, c_done;
  logic [SIZE_W-1:0] a_val;
  logic [MOD_W-1:0]  a_mod, a_rem, b_rem, c_rem;

  // cell row
  cmd_t cmd;
  req_t req;
  rec_t chain [0:FREE_ENTRIES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_bytes_r <= '0;
      grow_bytes_r <= GROW_RESET;
      pool_limit_r <= LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_INIT:  init_bytes_r <= cfg_data;
        REG_GROW:  grow_bytes_r <= cfg_data;
        REG_LIMIT: pool_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // unit a does the alignment first, then the page rounding of the size
  assign a_go  = (state_r == S_RNDGO) || (state_r == S_PRIME);
  assign bc_go = (state_r == S_RNDGO);
  assign a_val = (state_r == S_PRIME) ? size_r : SIZE_W'(bytes_r);
  assign a_mod = (state_r == S_PRIME) ? MOD_W'(PAGE_BYTES) : MOD_W'(ALIGN_BYTES);

  bfa_mod u_mod_a (
    .clk(clk), .rst_n(rst_n), .start(a_go), .val(a_val), .modulus(a_mod),
    .done(a_done), .rem(a_rem)
  );
  bfa_mod u_mod_b (
    .clk(clk), .rst_n(rst_n), .start(bc_go), .val(SIZE_W'(grow_bytes_r)),
    .modulus(MOD_W'(PAGE_BYTES)), .done(b_done), .rem(b_rem)
  );
  bfa_mod u_mod_c (
    .clk(clk), .rst_n(rst_n), .start(bc_go), .val(SIZE_W'(init_bytes_r)),
    .modulus(MOD_W'(PAGE_BYTES)), .done(c_done), .rem(c_rem)
  );

  // round up: add the distance to the next multiple when the remainder is nonzero
  function automatic logic [SIZE_W-1:0] rnd_up(input logic [SIZE_W-1:0] v,
                                               input logic [MOD_W-1:0]  r,
                                               input logic [MOD_W-1:0]  m);
    return (r == '0) ? v : v + SIZE_W'(m) - SIZE_W'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (state_r == S_RND && a_done && b_done && c_done) begin
      size_r    <= rnd_up(SIZE_W'(bytes_r), a_rem, MOD_W'(ALIGN_BYTES));
      grow_pg_r <= rnd_up(SIZE_W'(grow_bytes_r), b_rem, MOD_W'(PAGE_BYTES));
      init_pg_r <= rnd_up(SIZE_W'(init_bytes_r), c_rem, MOD_W'(PAGE_BYTES));
    end
    if (state_r != S_RND && a_done)
      size_pg_r <= rnd_up(size_r, a_rem, MOD_W'(PAGE_BYTES));
    if (state_r == S_SCAN && chain[FREE_ENTRIES].vld)
      scan_r <= chain[FREE_ENTRIES];
    if (in_valid && in_ready) begin
      op_r    <= in_op;
      addr_r  <= in_region_addr;
      bytes_r <= in_region_bytes;
    end
  end

  // request view broadcast to every cell
  assign req = {size_r, addr_r, EXT_W'(addr_r) + EXT_W'(size_r)};

  // scan token enters at cell 0
  always_comb begin
    chain[0]     = '0;
    chain[0].vld = (state_r == S_SCANGO);
  end

  for (genvar i = 0; i < FREE_ENTRIES; i++) begin : g_cell
    bfa_cell u_cell (
      .clk(clk), .rst_n(rst_n), .idx(ENT_W'(i)), .req(req), .cmd(cmd),
      .rec_in(chain[i]), .rec_out(chain[i+1])
    );
  end

  // decisions and table writes
  always_comb begin
    logic [SIZE_W-1:0] part, rest, prime_amt;
    logic [EXT_W-1:0]  grown;
    state_nxt    = state_r;
    cmd          = '0;
    pool_end_nxt = pool_end_r;
    primed_nxt   = primed_r;
    res_addr_nxt = res_addr_r;
    res_st_nxt   = res_st_r;
    in_ready     = 1'b0;
    prime_amt    = (init_pg_r > grow_pg_r) ? init_pg_r : grow_pg_r;
    part         = (size_pg_r > grow_pg_r) ? size_pg_r : grow_pg_r;
    rest         = scan_r.best_size - size_r;
    grown        = EXT_W'(pool_end_r) + EXT_W'(part);
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = S_RNDGO;
      end
      S_RNDGO: state_nxt = S_RND;
      S_RND: begin
        if (a_done && b_done && c_done) state_nxt = S_PRIME;
      end
      S_PRIME: begin
        // first request after reset carves the opening chunk at offset 0 when it is nonzero and fits the limit
        if (!primed_r) begin
          primed_nxt = 1'b1;
          if (prime_amt != '0 &&
              EXT_W'(pool_end_r) + EXT_W'(prime_amt) <= EXT_W'(pool_limit_r)) begin
            cmd.we       = 1'b1;
            cmd.widx     = '0;
            cmd.wstart   = pool_end_r[ADDR_W-1:0];
            cmd.wsize    = prime_amt;
            pool_end_nxt = pool_end_r + prime_amt;
          end
        end
        state_nxt = S_SCANGO;
      end
      S_SCANGO: state_nxt = S_SCAN;
      S_SCAN: begin
        if (scan_done_r && pg_done_r) state_nxt = S_UPD;
      end
      S_UPD: begin
        res_addr_nxt = '0;
        res_st_nxt   = ST_OK;
        if (!op_r) begin
          if (scan_r.best_hit) begin
            // best fit found: shrink it, or drop it when used up
            res_addr_nxt = scan_r.best_start;
            if (rest == '0) begin
              cmd.clr  = 1'b1;
              cmd.cidx = scan_r.best_idx;
            end else begin
              cmd.we     = 1'b1;
              cmd.widx   = scan_r.best_idx;
              cmd.wstart = scan_r.best_start + size_r[ADDR_W-1:0];
              cmd.wsize  = rest;
            end
          end else if (grown > EXT_W'(pool_limit_r)) begin
            res_st_nxt = ST_SPACE;
          end else if (part != size_r && !scan_r.emp_hit) begin
            res_st_nxt = ST_FULL;
          end else begin
            // grow the pool; any tail of the new part becomes a free chunk
            res_addr_nxt = pool_end_r[ADDR_W-1:0];
            pool_end_nxt = grown[SIZE_W-1:0];
            if (part != size_r) begin
              cmd.we     = 1'b1;
              cmd.widx   = scan_r.emp_idx;
              cmd.wstart = pool_end_r[ADDR_W-1:0] + size_r[ADDR_W-1:0];
              cmd.wsize  = part - size_r;
            end
          end
        end else begin
          if (size_r == '0) begin
            res_st_nxt = ST_ZERO;
          end else if (req.span_end > EXT_W'(pool_end_r)) begin
            res_st_nxt = ST_SPACE;
          end else if (scan_r.ovl) begin
            res_st_nxt = ST_OVERLAP;
          end else if (scan_r.low_hit) begin
            // merge into the lower neighbor, absorbing the upper one too when it adjoins
            cmd.we     = 1'b1;
            cmd.widx   = scan_r.low_idx;
            cmd.wstart = scan_r.low_start;
            cmd.wsize  = scan_r.low_size + size_r +
                         (scan_r.up_hit ? scan_r.up_size : '0);
            cmd.clr    = scan_r.up_hit;
            cmd.cidx   = scan_r.up_idx;
          end else if (scan_r.up_hit) begin
            cmd.we     = 1'b1;
            cmd.widx   = scan_r.up_idx;
            cmd.wstart = addr_r;
            cmd.wsize  = size_r + scan_r.up_size;
          end else if (scan_r.emp_hit) begin
            cmd.we     = 1'b1;
            cmd.widx   = scan_r.emp_idx;
            cmd.wstart = addr_r;
            cmd.wsize  = size_r;
          end else begin
            res_st_nxt = ST_FULL;
          end
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pool_end_r  <= '0;
      primed_r    <= 1'b0;
      pg_done_r   <= 1'b0;
      scan_done_r <= 1'b0;
      out_valid_r <= 1'b0;
      res_st_r    <= ST_OK;
      res_addr_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      pool_end_r <= pool_end_nxt;
      primed_r   <= primed_nxt;
      res_addr_r <= res_addr_nxt;
      res_st_r   <= res_st_nxt;
      if (state_r == S_PRIME) begin
        pg_done_r   <= 1'b0;
        scan_done_r <= 1'b0;
      end else begin
        if (state_r != S_RND && a_done) pg_done_r <= 1'b1;
        if (state_r == S_SCAN && chain[FREE_ENTRIES].vld) scan_done_r <= 1'b1;
      end
      if (state_r == S_DONE && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_addr_r <= res_addr_r;
      out_st_r   <= res_st_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_alloc_addr = out_addr_r;
  assign out_status     = out_st_r;

endmodule

// ===== rtl/bfa_mod.sv =====
// remainder unit for a power-of-two modulus, result registered in the cycle after start
// depends on bfa_pkg
`timescale 1ns / 1ps
module bfa_mod import bfa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SIZE_W-1:0] val,
  input  logic [MOD_W-1:0]  modulus,
  output logic              done,
  output logic [MOD_W-1:0]  rem
);

  logic [MOD_W-1:0] rem_r, rem_nxt;
  logic             done_r;

  // low bits below the modulus
  assign rem_nxt = val[MOD_W-1:0] & (modulus - MOD_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/bfa_cell.sv =====
// one free-chunk cell: holds an entry and folds it into the passing scan record
// depends on bfa_pkg
`timescale 1ns / 1ps
module bfa_cell import bfa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [ENT_W-1:0] idx,
  input  req_t             req,
  input  cmd_t             cmd,
  input  rec_t             rec_in,
  output rec_t             rec_out
);

  logic [ADDR_W-1:0] start_r;
  logic [SIZE_W-1:0] size_r;
  logic              valid_r;
  rec_t              rec_r, rec_nxt;
  logic [EXT_W-1:0]  e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.we && cmd.widx == idx) begin
      valid_r <= 1'b1;
    end else if (cmd.clr && cmd.cidx == idx) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.we && cmd.widx == idx) begin
      start_r <= cmd.wstart;
      size_r  <= cmd.wsize;
    end
  end

  always_comb begin
    e = EXT_W'(start_r) + EXT_W'(size_r);
    rec_nxt = rec_in;
    if (rec_in.vld) begin
      if (valid_r && size_r >= req.size &&
          (!rec_in.best_hit || size_r < rec_in.best_size ||
           (size_r == rec_in.best_size && start_r < rec_in.best_start))) begin
        rec_nxt.best_hit   = 1'b1;
        rec_nxt.best_idx   = idx;
        rec_nxt.best_start = start_r;
        rec_nxt.best_size  = size_r;
      end
      if (valid_r && EXT_W'(start_r) < req.span_end && EXT_W'(req.addr) < e)
        rec_nxt.ovl = 1'b1;
      if (valid_r && e == EXT_W'(req.addr)) begin
        rec_nxt.low_hit   = 1'b1;
        rec_nxt.low_idx   = idx;
        rec_nxt.low_start = start_r;
        rec_nxt.low_size  = size_r;
      end
      if (valid_r && EXT_W'(start_r) == req.span_end) begin
        rec_nxt.up_hit  = 1'b1;
        rec_nxt.up_idx  = idx;
        rec_nxt.up_size = size_r;
      end
      if (!valid_r && !rec_in.emp_hit) begin
        rec_nxt.emp_hit = 1'b1;
        rec_nxt.emp_idx = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rec_r <= '0;
    else        rec_r <= rec_nxt;
  end

  assign rec_out = rec_r;

endmodule

// ===== rtl/bfa_checker.sv =====
// port-level checker for the best-fit allocator, bound to the top level
// depends on bfa_pkg and best_fit_coalescing_allocator_defines.svh
`timescale 1ns / 1ps
`include "best_fit_coalescing_allocator_defines.svh"
module bfa_checker import bfa_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_alloc_addr,
  input logic [2:0]  out_status
);

  // a stalled result holds
  `BFA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({out_alloc_addr, out_status}))

  // status stays within the defined codes
  `BFA_ASSERT_NOW(a_status_rng, out_valid, out_status <= ST_ZERO)

  // an error never hands out an address
  `BFA_ASSERT_NOW(a_err_addr, out_valid && out_status != ST_OK, out_alloc_addr == '0)

  // one request in flight: no back-to-back accept
  `BFA_ASSERT_NXT(a_one_req, in_valid && in_ready, !in_ready)

endmodule

bind best_fit_coalescing_allocator bfa_checker u_bfa_checker (.*);
